// ----- src/mtp_pkg.sv -----
// shared types, codes and tables of the midi track event parser
`timescale 1ns / 1ps

package mtp_pkg;

  localparam int VARLEN_MAX_BYTES_DEFAULT = 4;
  localparam int TAG_BYTES = 4;
  localparam int ACC_W = 28;

  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [7:0] META_EOT      = 8'h2F;

  typedef enum logic [3:0] {
    PH_WAIT,
    PH_ID,
    PH_LEN,
    PH_DELTA,
    PH_STATUS,
    PH_PARAM1,
    PH_PARAM2,
    PH_METATYPE,
    PH_DATALEN,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL,
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_CHUNK_ID,
    ERR_VARLEN,
    ERR_STATUS
  } err_t;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         byte_count;
    logic [7:0]         running_status;
    logic [ACC_W-1:0]   delta_accum;
    logic [ACC_W-1:0]   length_accum;
    logic [ACC_W-1:0]   remaining_bytes;
    logic [7:0]         held_param;
    logic [7:0]         held_meta_type;
  } state_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [7:0]         ev_status;
    logic [3:0]         channel;
    logic [7:0]         param_first;
    logic [7:0]         param_second;
    logic [ACC_W-1:0]   delta_ticks;
    logic [7:0]         meta_type;
    logic [ACC_W-1:0]   payload_length;
    logic [7:0]         payload_byte;
    logic               last;
    logic               end_of_track;
    err_t               error_code;
  } result_t;

  // chunk identifier "MTrk"
  function automatic logic [7:0] chunk_tag(input logic [1:0] idx);
    case (idx)
      2'd0:    chunk_tag = 8'h4D;
      2'd1:    chunk_tag = 8'h54;
      2'd2:    chunk_tag = 8'h72;
      default: chunk_tag = 8'h6B;
    endcase
  endfunction

  function automatic logic is_two_param(input logic [7:0] status);
    case (status[7:4]) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: is_two_param = 1'b1;
      default:                      is_two_param = 1'b0;
    endcase
  endfunction

endpackage

// ----- src/mtp_in_if.sv -----
// input byte channel of the midi track event parser
`timescale 1ns / 1ps

interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_track;

  modport source (output valid, output data_byte, output new_track, input ready);
  modport sink   (input valid, input data_byte, input new_track, output ready);
endinterface

// ----- src/mtp_out_if.sv -----
// result channel of the midi track event parser
`timescale 1ns / 1ps

interface mtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  ev_status;
  logic [3:0]  channel;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [27:0] delta_ticks;
  logic [7:0]  meta_type;
  logic [27:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;
  logic        end_of_track;
  logic [1:0]  error_code;

  modport source (
    output valid, output kind, output ev_status, output channel,
    output param_first, output param_second, output delta_ticks,
    output meta_type, output payload_length, output payload_byte,
    output last, output end_of_track, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input ev_status, input channel,
    input param_first, input param_second, input delta_ticks,
    input meta_type, input payload_length, input payload_byte,
    input last, input end_of_track, input error_code, output ready
  );
endinterface

// ----- src/mtp_decode.sv -----
// one-byte step of the track parser: next state and optional result
`timescale 1ns / 1ps

module mtp_decode #(
  parameter int VARLEN_MAX_BYTES = mtp_pkg::VARLEN_MAX_BYTES_DEFAULT
) (
  input  mtp_pkg::state_t  st,
  input  logic [7:0]       data_byte,
  input  logic             new_track,
  output mtp_pkg::state_t  st_next,
  output mtp_pkg::result_t res
);
  import mtp_pkg::*;

  localparam logic [3:0] VL_LIMIT = 4'(VARLEN_MAX_BYTES);

  state_t           cur;
  logic [ACC_W-1:0] vl_src;
  logic [ACC_W-1:0] vl_acc;
  logic             vl_more;
  logic [3:0]       vl_n;
  logic             vl_over;
  logic [ACC_W-1:0] rem_dec;
  logic             fin_wait;
  logic             two_rs;
  logic             is_data_status;

  function automatic state_t go_delta(input state_t s);
    state_t r;
    r = s;
    r.phase = PH_DELTA;
    r.byte_count = '0;
    r.delta_accum = '0;
    return r;
  endfunction

  function automatic state_t go_wait(input state_t s);
    state_t r;
    r = s;
    r.phase = PH_WAIT;
    r.byte_count = '0;
    return r;
  endfunction

  // new track clears everything and restarts at the chunk id
  always_comb begin
    cur = st;
    if (new_track) begin
      cur = '0;
      cur.phase = PH_ID;
    end
  end

  assign vl_src   = (cur.phase == PH_DELTA) ? cur.delta_accum : cur.length_accum;
  assign vl_acc   = {vl_src[ACC_W-8:0], data_byte[6:0]};
  assign vl_more  = data_byte[7];
  assign vl_n     = {1'b0, cur.byte_count} + 4'd1;
  assign vl_over  = vl_more && (vl_n >= VL_LIMIT);
  assign rem_dec  = cur.remaining_bytes - ACC_W'(1);
  assign fin_wait = (cur.held_param == STATUS_META) && (cur.held_meta_type == META_EOT);
  assign two_rs   = is_two_param(cur.running_status);
  assign is_data_status = (data_byte == STATUS_SYSEX) || (data_byte == STATUS_ESCAPE) ||
                          (data_byte == STATUS_META);

  // next state
  always_comb begin
    st_next = cur;
    case (cur.phase)
      PH_ID: begin
        if (data_byte != chunk_tag(cur.byte_count[1:0])) begin
          st_next = go_wait(cur);
        end else if (cur.byte_count == 3'(TAG_BYTES - 1)) begin
          st_next.phase = PH_LEN;
          st_next.byte_count = '0;
        end else begin
          st_next.byte_count = cur.byte_count + 3'd1;
        end
      end
      PH_LEN: begin
        if (cur.byte_count == 3'(TAG_BYTES - 1)) begin
          st_next = go_delta(cur);
        end else begin
          st_next.byte_count = cur.byte_count + 3'd1;
        end
      end
      PH_DELTA: begin
        st_next.delta_accum = vl_acc;
        if (!vl_more) begin
          st_next.phase = PH_STATUS;
          st_next.byte_count = '0;
        end else if (vl_over) begin
          st_next.phase = PH_WAIT;
          st_next.byte_count = '0;
        end else begin
          st_next.byte_count = vl_n[2:0];
        end
      end
      PH_STATUS: begin
        if (!data_byte[7]) begin
          if (cur.running_status == 8'h00) begin
            st_next = go_wait(cur);
          end else if (two_rs) begin
            st_next.held_param = data_byte;
            st_next.phase = PH_PARAM2;
          end else begin
            st_next = go_delta(cur);
          end
        end else if (data_byte < STATUS_SYSEX) begin
          st_next.running_status = data_byte;
          st_next.phase = PH_PARAM1;
        end else if (is_data_status) begin
          st_next.running_status = '0;
          st_next.held_param = data_byte;
          st_next.held_meta_type = '0;
          st_next.length_accum = '0;
          st_next.byte_count = '0;
          st_next.phase = (data_byte == STATUS_META) ? PH_METATYPE : PH_DATALEN;
        end else begin
          st_next = go_wait(cur);
        end
      end
      PH_PARAM1: begin
        if (two_rs) begin
          st_next.held_param = data_byte;
          st_next.phase = PH_PARAM2;
        end else begin
          st_next = go_delta(cur);
        end
      end
      PH_PARAM2: begin
        st_next = go_delta(cur);
      end
      PH_METATYPE: begin
        st_next.held_meta_type = data_byte;
        st_next.phase = PH_DATALEN;
        st_next.byte_count = '0;
      end
      PH_DATALEN: begin
        st_next.length_accum = vl_acc;
        if (vl_over) begin
          st_next.phase = PH_WAIT;
          st_next.byte_count = '0;
        end else if (vl_more) begin
          st_next.byte_count = vl_n[2:0];
        end else begin
          st_next.remaining_bytes = vl_acc;
          st_next.byte_count = '0;
          if (vl_acc == '0) begin
            st_next = fin_wait ? go_wait(st_next) : go_delta(st_next);
          end else begin
            st_next.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        st_next.remaining_bytes = rem_dec;
        if (rem_dec == '0) begin
          st_next = fin_wait ? go_wait(st_next) : go_delta(st_next);
        end
      end
      default: begin
        st_next = cur;
      end
    endcase
  end

  // result
  always_comb begin
    res = '0;
    case (cur.phase)
      PH_ID: begin
        if (data_byte != chunk_tag(cur.byte_count[1:0])) begin
          res.valid = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_CHUNK_ID;
        end
      end
      PH_DELTA: begin
        if (vl_over) begin
          res.valid = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_VARLEN;
        end
      end
      PH_STATUS, PH_PARAM1, PH_PARAM2: begin
        res.kind = KIND_CHANNEL;
        res.ev_status = {cur.running_status[7:4], 4'h0};
        res.channel = cur.running_status[3:0];
        res.delta_ticks = cur.delta_accum;
        res.last = 1'b1;
        if (cur.phase == PH_PARAM2) begin
          res.valid = 1'b1;
          res.param_first = cur.held_param;
          res.param_second = data_byte;
        end else begin
          res.param_first = data_byte;
          res.valid = (cur.phase == PH_PARAM1) ? !two_rs
                    : (!data_byte[7] && cur.running_status != 8'h00 && !two_rs);
        end
        if (cur.phase == PH_STATUS &&
            ((!data_byte[7] && cur.running_status == 8'h00) ||
             (data_byte >= STATUS_SYSEX && !is_data_status))) begin
          res = '0;
          res.valid = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_STATUS;
        end
      end
      PH_DATALEN, PH_PAYLOAD: begin
        res.ev_status = cur.held_param;
        res.delta_ticks = cur.delta_accum;
        if (cur.held_param == STATUS_META) begin
          res.meta_type = cur.held_meta_type;
          res.end_of_track = (cur.held_meta_type == META_EOT);
        end
        if (cur.phase == PH_PAYLOAD) begin
          res.valid = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.payload_length = cur.length_accum;
          res.payload_byte = data_byte;
          res.last = (rem_dec == '0);
        end else if (vl_over) begin
          res = '0;
          res.valid = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_VARLEN;
        end else begin
          res.valid = !vl_more;
          res.kind = KIND_HEADER;
          res.payload_length = vl_acc;
          res.last = (vl_acc == '0);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- src/midi_track_event_parser.sv -----
// top level of the midi track event parser
//
// track: one byte of a track chunk per word, with new_track marking the
//   first byte of a chunk; new_track clears all parser state and running
//   status, and the byte is checked as the first id byte.
// events: zero or one result word per input byte: channel events, sysex
//   or meta headers, payload bytes, end of track and errors.
// a byte taken into the input register is decoded into the output register,
//   which holds its result word until the receiver takes it.
// throughput: one byte per cycle while the receiver takes the words; the
//   parser state machine and its variable-length accumulators update once per byte.
// a stalled receiver holds the output register; the input register then
//   holds the next byte and ready drops until the output word is taken.
// reset: synchronous, clears both registers' valid flags and puts the
//   parser in the wait-for-new-track state; bytes without new_track are
//   dropped while waiting.
`timescale 1ns / 1ps

module midi_track_event_parser #(
  parameter int VARLEN_MAX_BYTES = mtp_pkg::VARLEN_MAX_BYTES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  mtp_in_if.sink    track,
  mtp_out_if.source events
);
  import mtp_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_data;
  logic       ir_new;
  logic       advance;
  logic       out_valid;
  state_t     state;
  state_t     state_next;
  result_t    res;
  result_t    out_word;

  mtp_decode #(
    .VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)
  ) u_decode (
    .st        (state),
    .data_byte (ir_data),
    .new_track (ir_new),
    .st_next   (state_next),
    .res       (res)
  );

  assign advance     = !out_valid || events.ready;
  assign track.ready = !ir_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (track.ready) begin
      ir_valid <= track.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (track.ready && track.valid) begin
      ir_data <= track.data_byte;
      ir_new  <= track.new_track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ir_valid && res.valid;
      if (ir_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ir_valid && res.valid) begin
      out_word <= res;
    end
  end

  assign events.valid          = out_valid;
  assign events.kind           = out_word.kind;
  assign events.ev_status      = out_word.ev_status;
  assign events.channel        = out_word.channel;
  assign events.param_first    = out_word.param_first;
  assign events.param_second   = out_word.param_second;
  assign events.delta_ticks    = out_word.delta_ticks;
  assign events.meta_type      = out_word.meta_type;
  assign events.payload_length = out_word.payload_length;
  assign events.payload_byte   = out_word.payload_byte;
  assign events.last           = out_word.last;
  assign events.end_of_track   = out_word.end_of_track;
  assign events.error_code     = out_word.error_code;

`ifndef SYNTH
  a_error_waits: assert property (@(posedge clk) disable iff (rst)
    (advance && ir_valid && res.valid && res.kind == KIND_ERROR) |=> state.phase == PH_WAIT)
    else $error("parser not waiting after error");

  a_eot_waits: assert property (@(posedge clk) disable iff (rst)
    (advance && ir_valid && res.valid && res.end_of_track && res.last)
      |=> state.phase == PH_WAIT)
    else $error("parser not waiting after end of track");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !events.ready) |=> $stable(state))
    else $error("parser state moved while output stalled");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench of the midi track event parser: directed and random tracks
`timescale 1ns / 1ps

module testbench;
  import mtp_pkg::*;

  localparam int VLQ_LIMIT = VARLEN_MAX_BYTES_DEFAULT;
  localparam int RAND_BYTES = 1050;
  localparam int WATCHDOG_LIMIT = 200;
  localparam logic [31:0] TRACK_TAG = 32'h4D54726B;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ev_status;
    logic [3:0]  channel;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [27:0] delta_ticks;
    logic [7:0]  meta_type;
    logic [27:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic        end_of_track;
    err_t        error_code;
  } parsed_word_t;

  logic clk;
  logic rst;

  mtp_in_if  byte_bus ();
  mtp_out_if word_bus ();

  midi_track_event_parser #(.VARLEN_MAX_BYTES(VLQ_LIMIT)) DUT (
    .clk(clk),
    .rst(rst),
    .track(byte_bus),
    .events(word_bus)
  );

  // parser mirror
  phase_t      pr_phase;
  logic [2:0]  pr_cnt;
  logic [7:0]  pr_running;
  logic [7:0]  pr_held;
  logic [7:0]  pr_meta;
  logic [27:0] pr_delta;
  logic [27:0] pr_len;
  logic [27:0] pr_left;

  parsed_word_t expected_words[$];
  parsed_word_t want;

  int parsed_bytes;
  int ignored_bytes;
  int checked_words;
  int error_words;
  int eot_events;
  int fail_cnt;
  int idle_cycles;
  int unsigned ready_hold;
  int unsigned ready_draw;
  bit no_idle;

  always #10 clk = ~clk;

  function automatic bit takes_two(input logic [7:0] st);
    return !(st[7:4] == 4'hC || st[7:4] == 4'hD);
  endfunction

  task clear_parser();
    pr_phase = PH_WAIT;
    pr_cnt = '0;
    pr_running = '0;
    pr_held = '0;
    pr_meta = '0;
    pr_delta = '0;
    pr_len = '0;
    pr_left = '0;
  endtask

  task start_delta();
    pr_phase = PH_DELTA;
    pr_cnt = '0;
    pr_delta = '0;
  endtask

  task make_error(output parsed_word_t w, input err_t code);
    w = '0;
    w.kind = KIND_ERROR;
    w.error_code = code;
    pr_phase = PH_WAIT;
    pr_cnt = '0;
  endtask

  task make_channel(output parsed_word_t w, input logic [7:0] p1, input logic [7:0] p2);
    w = '0;
    w.kind = KIND_CHANNEL;
    w.ev_status = {pr_running[7:4], 4'h0};
    w.channel = pr_running[3:0];
    w.param_first = p1;
    w.param_second = p2;
    w.delta_ticks = pr_delta;
    w.last = 1'b1;
    start_delta();
  endtask

  task make_data(output parsed_word_t w, input kind_t k);
    w = '0;
    w.kind = k;
    w.ev_status = pr_held;
    w.delta_ticks = pr_delta;
    if (pr_held == STATUS_META) begin
      w.meta_type = pr_meta;
      w.end_of_track = (pr_meta == META_EOT);
    end
    w.payload_length = pr_len;
  endtask

  task close_data_event();
    if (pr_held == STATUS_META && pr_meta == META_EOT) begin
      pr_phase = PH_WAIT;
      pr_cnt = '0;
      eot_events++;
    end else begin
      start_delta();
    end
  endtask

  // 1 done, 0 more bytes follow, -1 too long
  task take_vlq(inout logic [27:0] acc, input logic [7:0] b, output int res);
    logic [3:0] n;
    n = {1'b0, pr_cnt} + 4'd1;
    acc = {acc[20:0], b[6:0]};
    if (!b[7]) begin
      res = 1;
    end else if (n >= VLQ_LIMIT) begin
      res = -1;
    end else begin
      pr_cnt = n[2:0];
      res = 0;
    end
  endtask

  task predict_word(input logic [7:0] b, input logic nt);
    parsed_word_t w;
    int res;
    bit emit;
    w = '0;
    emit = 0;
    if (nt) begin
      clear_parser();
      pr_phase = PH_ID;
    end
    if (pr_phase == PH_WAIT) ignored_bytes++;
    else parsed_bytes++;
    case (pr_phase)
      PH_ID: begin
        if (b != TRACK_TAG[31 - 8 * pr_cnt[1:0] -: 8]) begin
          make_error(w, ERR_CHUNK_ID);
          emit = 1;
        end else begin
          pr_cnt++;
          if (pr_cnt >= 4) begin
            pr_phase = PH_LEN;
            pr_cnt = '0;
          end
        end
      end
      PH_LEN: begin
        pr_cnt++;
        if (pr_cnt >= 4) start_delta();
      end
      PH_DELTA: begin
        take_vlq(pr_delta, b, res);
        if (res < 0) begin
          make_error(w, ERR_VARLEN);
          emit = 1;
        end else if (res > 0) begin
          pr_phase = PH_STATUS;
          pr_cnt = '0;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (pr_running == 0) begin
            make_error(w, ERR_STATUS);
            emit = 1;
          end else if (takes_two(pr_running)) begin
            pr_held = b;
            pr_phase = PH_PARAM2;
          end else begin
            make_channel(w, b, 8'h00);
            emit = 1;
          end
        end else if (b < STATUS_SYSEX) begin
          pr_running = b;
          pr_phase = PH_PARAM1;
        end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE || b == STATUS_META) begin
          pr_running = '0;
          pr_held = b;
          pr_meta = '0;
          pr_len = '0;
          pr_cnt = '0;
          pr_phase = (b == STATUS_META) ? PH_METATYPE : PH_DATALEN;
        end else begin
          make_error(w, ERR_STATUS);
          emit = 1;
        end
      end
      PH_PARAM1: begin
        if (takes_two(pr_running)) begin
          pr_held = b;
          pr_phase = PH_PARAM2;
        end else begin
          make_channel(w, b, 8'h00);
          emit = 1;
        end
      end
      PH_PARAM2: begin
        make_channel(w, pr_held, b);
        emit = 1;
      end
      PH_METATYPE: begin
        pr_meta = b;
        pr_phase = PH_DATALEN;
        pr_cnt = '0;
      end
      PH_DATALEN: begin
        take_vlq(pr_len, b, res);
        if (res < 0) begin
          make_error(w, ERR_VARLEN);
          emit = 1;
        end else if (res > 0) begin
          make_data(w, KIND_HEADER);
          pr_left = pr_len;
          pr_cnt = '0;
          emit = 1;
          if (pr_left == 0) begin
            w.last = 1'b1;
            close_data_event();
          end else begin
            pr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        make_data(w, KIND_PAYLOAD);
        w.payload_byte = b;
        pr_left = pr_left - 28'd1;
        emit = 1;
        if (pr_left == 0) begin
          w.last = 1'b1;
          close_data_event();
        end
      end
      default: ;
    endcase
    if (emit) begin
      expected_words.push_back(w);
      if (w.kind == KIND_ERROR) error_words++;
    end
  endtask

  // sends one byte and mirrors it once accepted
  task send_byte(input logic [7:0] b, input logic nt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.new_track <= nt;
    do @(posedge clk); while (!(byte_bus.valid && byte_bus.ready));
    predict_word(b, nt);
  endtask

  task settle();
    byte_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task send_vlq(input logic [27:0] v, input int pad);
    int top;
    int n;
    int i;
    top = 0;
    for (i = 1; i < 4; i++) begin
      if (v[7 * i +: 7] != 0) top = i;
    end
    n = (pad > top + 1) ? pad : top + 1;
    for (i = n - 1; i >= 0; i--) send_byte({i != 0, v[7 * i +: 7]}, 1'b0);
  endtask

  task send_track_head();
    int i;
    for (i = 0; i < 4; i++) send_byte(TRACK_TAG[31 - 8 * i -: 8], i == 0);
    repeat (4) send_byte(8'($urandom), 1'b0);
  endtask

  function automatic int pick_pad();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, VLQ_LIMIT) : 0;
  endfunction

  function automatic logic [7:0] param_byte();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                        : 8'($urandom_range(0, 127));
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
  endfunction

  task send_rand_delta();
    int sel;
    logic [27:0] v;
    sel = $urandom_range(0, 9);
    if (sel < 6) v = 28'($urandom_range(0, 127));
    else if (sel < 8) v = 28'($urandom_range(0, 16383));
    else v = 28'($urandom);
    send_vlq(v, pick_pad());
  endtask

  task send_data_event(input logic [7:0] st, input logic [7:0] mt, input int len,
                       output bit ok);
    send_byte(st, 1'b0);
    if (st == STATUS_META) send_byte(mt, 1'b0);
    if ($urandom_range(0, 39) == 0) begin
      repeat (VLQ_LIMIT) send_byte({1'b1, 7'($urandom)}, 1'b0);
      ok = 0;
      return;
    end
    ok = 1;
    send_vlq(28'(len), pick_pad());
    repeat (len) send_byte(8'($urandom), 1'b0);
  endtask

  task test_idle_and_chunk_id();
    send_byte(8'h4D, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h4D, 1'b1);
    send_byte(8'h54, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h6B, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();
  endtask

  task test_channel_events();
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'h92, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    // running status, parameter with bit 7 set
    send_vlq(28'h7F, 0); send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
    send_vlq(28'hFFFFFFF, 0); send_byte(8'hCF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_vlq(28'h3FFF, 0); send_byte(8'hD3, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hE0, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h40, 1'b0);
    send_vlq(28'h1, 4); send_byte(8'hA5, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hB1, 1'b0);
    send_byte(8'h07, 1'b0); send_byte(8'h64, 1'b0);
    settle();
  endtask

  task test_sysex_and_meta();
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(STATUS_SYSEX, 1'b0); send_vlq(28'd3, 0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(STATUS_ESCAPE, 1'b0); send_vlq(28'd0, 0);
    send_byte(8'h00, 1'b0); send_byte(STATUS_META, 1'b0); send_byte(8'h01, 1'b0);
    send_vlq(28'd2, 3); send_byte(8'h41, 1'b0); send_byte(8'h42, 1'b0);
    // running status was cancelled by the data events
    send_byte(8'h00, 1'b0); send_byte(8'h40, 1'b0);
    settle();
  endtask

  task test_long_quantity();
    send_track_head();
    send_byte(8'h80, 1'b0); send_byte(8'h81, 1'b0);
    send_byte(8'h82, 1'b0); send_byte(8'h83, 1'b0);
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(STATUS_META, 1'b0); send_byte(8'h05, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    settle();
  endtask

  task test_undefined_status();
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'hF1, 1'b0);
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'hFE, 1'b0);
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'h55, 1'b0);
    settle();
  endtask

  task test_end_of_track();
    // new track in the middle of an event clears running status
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h3C, 1'b0);
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(8'h40, 1'b0);
    send_track_head();
    send_byte(8'h00, 1'b0); send_byte(STATUS_META, 1'b0); send_byte(META_EOT, 1'b0);
    send_vlq(28'd2, 0); send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'h90, 1'b0);
    send_track_head();
    send_vlq(28'h81, 0); send_byte(STATUS_META, 1'b0); send_byte(META_EOT, 1'b0);
    send_vlq(28'd0, 0);
    settle();
  endtask

  task rand_track();
    int n_events;
    int sel;
    int i;
    int bad_at;
    logic [7:0] rs;
    logic [7:0] st;
    logic [7:0] mt;
    bit have_rs;
    bit ok;
    no_idle = ($urandom_range(0, 3) == 0);
    bad_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : 4;
    for (i = 0; i < 4; i++) begin
      if (i == bad_at) begin
        send_byte(TRACK_TAG[31 - 8 * i -: 8] ^ 8'($urandom_range(1, 255)), i == 0);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        return;
      end
      send_byte(TRACK_TAG[31 - 8 * i -: 8], i == 0);
    end
    repeat (4) send_byte(8'($urandom), 1'b0);
    have_rs = 0;
    rs = '0;
    n_events = $urandom_range(1, 24);
    for (i = 0; i < n_events; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        repeat (VLQ_LIMIT) send_byte({1'b1, 7'($urandom)}, 1'b0);
        return;
      end
      send_rand_delta();
      if (sel < 40 || (sel < 60 && !have_rs)) begin
        rs = {4'($urandom_range(8, 14)), 4'($urandom)};
        have_rs = 1;
        send_byte(rs, 1'b0);
        send_byte(param_byte(), 1'b0);
        if (takes_two(rs)) send_byte(param_byte(), 1'b0);
      end else if (sel < 60) begin
        send_byte({1'b0, 7'($urandom)}, 1'b0);
        if (takes_two(rs)) send_byte(param_byte(), 1'b0);
      end else if (sel < 73) begin
        have_rs = 0;
        st = $urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE;
        send_data_event(st, 8'h00, pick_len(), ok);
        if (!ok) return;
      end else if (sel < 94) begin
        have_rs = 0;
        mt = 8'($urandom);
        if (mt == META_EOT) mt = 8'h01;
        send_data_event(STATUS_META, mt, pick_len(), ok);
        if (!ok) return;
      end else if (sel < 96) begin
        do st = 8'($urandom_range(241, 254)); while (st == STATUS_ESCAPE);
        send_byte(st, 1'b0);
        return;
      end else if (sel < 98 && !have_rs) begin
        send_byte({1'b0, 7'($urandom)}, 1'b0);
        return;
      end else begin
        // cut off mid-event, the next track restarts the parser
        return;
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_rand_delta();
      send_data_event(STATUS_META, META_EOT,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, ok);
      if (ok && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task test_random_tracks();
    int base;
    base = parsed_bytes;
    while (parsed_bytes - base < RAND_BYTES) rand_track();
    no_idle = 0;
  endtask

  function void check_field(input string name, input logic [27:0] exp_val,
                            input logic [27:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      fail_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && word_bus.valid && word_bus.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d", word_bus.kind);
        fail_cnt++;
      end else begin
        want = expected_words.pop_front();
        checked_words++;
        check_field("kind", 28'(want.kind), 28'(word_bus.kind));
        check_field("ev_status", 28'(want.ev_status), 28'(word_bus.ev_status));
        check_field("channel", 28'(want.channel), 28'(word_bus.channel));
        check_field("param_first", 28'(want.param_first), 28'(word_bus.param_first));
        check_field("param_second", 28'(want.param_second), 28'(word_bus.param_second));
        check_field("delta_ticks", want.delta_ticks, word_bus.delta_ticks);
        check_field("meta_type", 28'(want.meta_type), 28'(word_bus.meta_type));
        check_field("payload_length", want.payload_length, word_bus.payload_length);
        check_field("payload_byte", 28'(want.payload_byte), 28'(word_bus.payload_byte));
        check_field("last", 28'(want.last), 28'(word_bus.last));
        check_field("end_of_track", 28'(want.end_of_track), 28'(word_bus.end_of_track));
        check_field("error_code", 28'(want.error_code), 28'(word_bus.error_code));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      word_bus.ready <= 1'b0;
      ready_hold <= 0;
    end else if (word_bus.valid && word_bus.ready) begin
      ready_draw = no_idle ? 0 : $urandom_range(0, 3);
      ready_hold <= ready_draw;
      word_bus.ready <= (ready_draw == 0);
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      word_bus.ready <= (ready_hold == 1);
    end else begin
      word_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_bus.valid && byte_bus.ready) || (word_bus.valid && word_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_bus.valid = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.new_track = 1'b0;
    no_idle = 0;
    fail_cnt = 0;
    parsed_bytes = 0;
    ignored_bytes = 0;
    checked_words = 0;
    error_words = 0;
    eot_events = 0;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_chunk_id();
    test_channel_events();
    test_sysex_and_meta();
    test_long_quantity();
    test_undefined_status();
    test_end_of_track();
    test_random_tracks();
    settle();
    repeat (6) @(posedge clk);
    $display("parsed %0d track bytes, %0d more dropped while waiting for a track",
             parsed_bytes, ignored_bytes);
    $display("checked %0d result words: %0d errors, %0d ends of track",
             checked_words, error_words, eot_events);
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
